>>> hw/rtl/rvx_pkg.sv
// Shared types, opcode constants and a helper function for the RV32I execute core.
package rvx_pkg;

    localparam int REG_COUNT = 32;
    localparam int RIDX_W    = $clog2(REG_COUNT);

    localparam logic [1:0] KIND_RETIRED = 2'd0;
    localparam logic [1:0] KIND_LOADREQ = 2'd1;
    localparam logic [1:0] KIND_STOPPED = 2'd2;
    localparam logic [1:0] KIND_PHASE   = 2'd3;

    localparam logic [1:0] CFG_INITIAL_PC = 2'd0;
    localparam logic [1:0] CFG_INITIAL_SP = 2'd1;
    localparam logic [1:0] CFG_HALT       = 2'd2;

    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6f;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_FENCE  = 7'h0f;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [31:0] SYS_ECALL  = 32'h0000_0073;
    localparam logic [31:0] SYS_EBREAK = 32'h0010_0073;
    localparam logic [31:0] SYS_MRET   = 32'h3020_0073;
    localparam logic [31:0] SYS_WFI    = 32'h1050_0073;

    typedef struct packed {
        logic        cmd;
        logic [31:0] word;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] instr_address;
        logic [31:0] instr_word;
        logic [4:0]  dest_index;
        logic [31:0] write_value;
        logic [31:0] data_address;
        logic [1:0]  lane_offset;
        logic [31:0] store_word;
        logic [3:0]  byte_mask;
        logic        store_flag;
        logic [31:0] next_fetch;
    } out_item_t;

    typedef struct packed {
        logic [1:0] index;
        logic [31:0] data;
    } cfg_t;

    function automatic logic [31:0] sext12(input logic [11:0] v);
        sext12 = {{20{v[11]}}, v};
    endfunction

endpackage

>>> hw/rtl/rvx_queue.sv
// Two-entry queue that holds items between the core's pipeline sections.
module rvx_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg;
    logic             rp_reg;
    logic [1:0]       cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign dout    = mem_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule

>>> hw/rtl/rvx_exec.sv
// Back end: register file, program counter, load tracking and result formation.
module rvx_exec (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  rvx_pkg::in_item_t in_item,
    output logic              in_ready,
    input  logic              cfg_we,
    input  rvx_pkg::cfg_t     cfg,
    output logic              out_valid,
    output rvx_pkg::out_item_t out_item,
    input  logic              out_ready
);
    import rvx_pkg::*;

    logic [31:0] rf_reg [REG_COUNT];
    logic [31:0] pc_reg;
    logic        halt_reg;
    logic        lw_reg;
    logic [2:0]  plt_reg;
    logic [4:0]  pdst_reg;
    logic [1:0]  plane_reg;
    logic [31:0] pword_reg;
    logic [31:0] paddr_reg;
    logic        ovalid_reg;
    out_item_t   oitem_reg;

    out_item_t   res;
    logic        wr;
    logic [4:0]  wr_idx;
    logic [31:0] wr_val;
    logic        new_lw;
    logic        upd;
    logic [31:0] npc;

    logic [31:0] ir;
    logic [6:0]  op;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] immi;
    logic [31:0] imms;
    logic [31:0] immb;
    logic [31:0] immj;
    logic [31:0] sum_ai;
    logic [31:0] sum_as;
    logic [4:0]  shamt;
    logic [31:0] ld;
    logic [31:0] alu_b;
    logic        illegal;
    logic        taken;
    logic [31:0] rv;
    logic [4:0]  sh;

    assign in_ready  = !ovalid_reg || out_ready;
    assign out_valid = ovalid_reg;
    assign out_item  = oitem_reg;

    assign ir   = in_item.word;
    assign op   = ir[6:0];
    assign rd   = ir[11:7];
    assign f3   = ir[14:12];
    assign f7   = ir[31:25];
    assign a    = (ir[19:15] == 5'd0) ? 32'd0 : rf_reg[ir[19:15]];
    assign b    = (ir[24:20] == 5'd0) ? 32'd0 : rf_reg[ir[24:20]];
    assign immi = sext12(ir[31:20]);
    assign imms = sext12({ir[31:25], ir[11:7]});
    assign immb = {{20{ir[31]}}, ir[7], ir[30:25], ir[11:8], 1'b0};
    assign immj = {{12{ir[31]}}, ir[19:12], ir[20], ir[30:21], 1'b0};
    assign sum_ai = a + immi;
    assign sum_as = a + imms;
    assign sh   = {plane_reg, 3'b000};

    always_comb
    begin
        res          = '0;
        res.instr_address = pc_reg;
        res.instr_word    = ir;
        res.next_fetch    = pc_reg;
        wr      = 1'b0;
        wr_idx  = rd;
        wr_val  = 32'd0;
        new_lw  = 1'b0;
        upd     = 1'b0;
        npc     = pc_reg + 32'd4;
        illegal = 1'b0;
        taken   = 1'b0;
        rv      = 32'd0;
        ld      = 32'd0;
        alu_b   = immi;
        shamt   = ir[24:20];
        if (halt_reg)
        begin
            res.kind = KIND_STOPPED;
        end
        else if (in_item.cmd != lw_reg)
        begin
            res.kind = KIND_PHASE;
        end
        else if (in_item.cmd)
        begin
            ld = ir >> sh;
            case (plt_reg)
                3'd0:    rv = {{24{ld[7]}}, ld[7:0]};
                3'd1:    rv = {{16{ld[15]}}, ld[15:0]};
                3'd4:    rv = {24'd0, ld[7:0]};
                3'd5:    rv = {16'd0, ld[15:0]};
                default: rv = ir;
            endcase
            wr     = 1'b1;
            wr_idx = pdst_reg;
            wr_val = rv;
            upd    = 1'b1;
            res.kind          = KIND_RETIRED;
            res.instr_word    = pword_reg;
            res.dest_index    = pdst_reg;
            res.write_value   = rv;
            res.data_address  = paddr_reg;
            res.lane_offset   = plane_reg;
            res.next_fetch    = pc_reg + 32'd4;
        end
        else
        begin
            rv = (rd == 5'd0) ? 32'd0 : rf_reg[rd];
            if (op == OP_REG)
            begin
                alu_b = b;
                shamt = b[4:0];
            end
            unique case (op)
                OP_LUI:   begin wr = 1'b1; rv = {ir[31:12], 12'd0}; end
                OP_AUIPC: begin wr = 1'b1; rv = pc_reg + {ir[31:12], 12'd0}; end
                OP_JAL:
                begin
                    wr = 1'b1; rv = pc_reg + 32'd4; npc = pc_reg + immj;
                end
                OP_JALR:
                begin
                    if (f3 != 3'd0) illegal = 1'b1;
                    wr = 1'b1; rv = pc_reg + 32'd4; npc = {sum_ai[31:1], 1'b0};
                end
                OP_BRANCH:
                begin
                    case (f3)
                        3'd0: taken = a == b;
                        3'd1: taken = a != b;
                        3'd4: taken = $signed(a) < $signed(b);
                        3'd5: taken = !($signed(a) < $signed(b));
                        3'd6: taken = a < b;
                        3'd7: taken = a >= b;
                        default: illegal = 1'b1;
                    endcase
                    if (taken) npc = pc_reg + immb;
                end
                OP_LOAD:
                begin
                    res.kind = KIND_LOADREQ;
                    res.dest_index = rd;
                    res.data_address = {sum_ai[31:2], 2'b00};
                    res.next_fetch = pc_reg + 32'd4;
                    case (f3)
                        3'd0, 3'd4: res.lane_offset = sum_ai[1:0];
                        3'd1, 3'd5: res.lane_offset = {sum_ai[1], 1'b0};
                        3'd2:       res.lane_offset = 2'd0;
                        default:    illegal = 1'b1;
                    endcase
                    new_lw = !illegal;
                end
                OP_STORE:
                begin
                    res.data_address = {sum_as[31:2], 2'b00};
                    res.store_flag = 1'b1;
                    case (f3)
                        3'd0:
                        begin
                            res.store_word = b << {sum_as[1:0], 3'b000};
                            res.byte_mask = 4'b0001 << sum_as[1:0];
                        end
                        3'd1:
                        begin
                            res.store_word = b << {sum_as[1], 4'b0000};
                            res.byte_mask = 4'b0011 << {sum_as[1], 1'b0};
                        end
                        3'd2:
                        begin
                            res.store_word = b;
                            res.byte_mask = 4'hf;
                        end
                        default: illegal = 1'b1;
                    endcase
                end
                OP_IMM, OP_REG:
                begin
                    wr = 1'b1;
                    if (op == OP_REG && f7 != 7'd0 &&
                        !(f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5)))
                    begin
                        illegal = 1'b1;
                    end
                    if (op == OP_IMM && f3 == 3'd1 && f7 != 7'd0) illegal = 1'b1;
                    if (op == OP_IMM && f3 == 3'd5 && f7 != 7'd0 && f7 != 7'h20)
                    begin
                        illegal = 1'b1;
                    end
                    case (f3)
                        3'd0: rv = (op == OP_REG && f7[5]) ? a - alu_b : a + alu_b;
                        3'd1: rv = a << shamt;
                        3'd2: rv = {31'd0, $signed(a) < $signed(alu_b)};
                        3'd3: rv = {31'd0, a < alu_b};
                        3'd4: rv = a ^ alu_b;
                        3'd5: rv = f7[5] ? 32'($signed(a) >>> shamt) : a >> shamt;
                        3'd6: rv = a | alu_b;
                        default: rv = a & alu_b;
                    endcase
                end
                OP_FENCE: if (f3 > 3'd1) illegal = 1'b1;
                OP_SYSTEM:
                begin
                    if (f3 == 3'd4) illegal = 1'b1;
                    if (f3 == 3'd0 && ir != SYS_ECALL && ir != SYS_EBREAK &&
                        ir != SYS_MRET && ir != SYS_WFI)
                    begin
                        illegal = 1'b1;
                    end
                end
                default: illegal = 1'b1;
            endcase
            if (illegal)
            begin
                res = '0;
                res.kind = KIND_STOPPED;
                res.instr_address = pc_reg;
                res.instr_word = ir;
                res.next_fetch = pc_reg;
                wr = 1'b0;
                new_lw = 1'b0;
            end
            else if (!new_lw)
            begin
                res.kind = KIND_RETIRED;
                res.dest_index = rd;
                res.write_value = rv;
                res.next_fetch = npc;
                upd = 1'b1;
            end
            wr_val = rv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            oitem_reg <= res;
            if (new_lw)
            begin
                plt_reg   <= f3;
                pdst_reg  <= rd;
                plane_reg <= res.lane_offset;
                pword_reg <= ir;
                paddr_reg <= res.data_address;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                rf_reg[i] <= 32'd0;
            end
            pc_reg     <= 32'd0;
            halt_reg   <= 1'b0;
            lw_reg     <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg.index)
                    CFG_INITIAL_PC: pc_reg <= cfg.data;
                    CFG_INITIAL_SP: rf_reg[2] <= cfg.data;
                    CFG_HALT:       halt_reg <= cfg.data[0];
                    default:        ;
                endcase
            end
            if (in_ready)
            begin
                ovalid_reg <= in_valid;
            end
            if (in_valid && in_ready)
            begin
                if (wr && wr_idx != 5'd0)
                begin
                    rf_reg[wr_idx] <= wr_val;
                end
                if (upd)
                begin
                    pc_reg <= res.next_fetch;
                    lw_reg <= 1'b0;
                end
                if (new_lw)
                begin
                    lw_reg <= 1'b1;
                end
            end
        end
    end
endmodule

>>> hw/rtl/rv32i_execute_core.sv
// Top level of the RV32I execute core: input queue, execute stage and result queue.
//
// Usage: supply instruction words (cmd 0) for the address given by next_fetch of the
// previous result, or the returned aligned data word (cmd 1) after a load request.
// The input side is a queue: an item transfers when push is high and full is low.
// The result side is a queue as well: the oldest result is shown while empty is low
// and transfers when pop is high.
// Configuration uses its own valid/ready channel (cfg_index, cfg_data); it is always
// ready. The user must write it only while the core is idle; the block does not
// enforce this. An accepted item passes through the input queue, the execute stage
// register and the result queue. Throughput is one item per cycle while the
// receiver keeps popping results, set by the execute stage with its register file.
// Reset zeroes the register file, sp included, and the program counter, and empties
// both queues. When the receiver stalls, the result queue fills, then the execute
// stage holds its result, and full rises once the input queue is full too.
module rv32i_execute_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rvx_pkg::in_item_t   in_item,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output rvx_pkg::out_item_t  out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import rvx_pkg::*;

    in_item_t  q_item;
    logic      q_empty;
    logic      x_ready;
    logic      x_valid;
    out_item_t x_item;
    logic      r_full;
    cfg_t      cfg;

    assign cfg_ready = 1'b1;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // Front queue decouples the supplier from the execute stage.
    rvx_queue #(.WIDTH($bits(in_item_t))) u_inq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (in_item),
        .full  (full),
        .pop   (x_ready),
        .dout  (q_item),
        .empty (q_empty)
    );

    rvx_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!q_empty),
        .in_item   (q_item),
        .in_ready  (x_ready),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg       (cfg),
        .out_valid (x_valid),
        .out_item  (x_item),
        .out_ready (!r_full)
    );

    // Result queue lets the execute stage run ahead of the consumer.
    rvx_queue #(.WIDTH($bits(out_item_t))) u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (x_valid),
        .din   (x_item),
        .full  (r_full),
        .pop   (pop),
        .dout  (out_item),
        .empty (empty)
    );

    // A result that cannot enter the result queue must stay in the execute stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        x_valid && r_full |=> x_valid && $stable(x_item))
        else $error("execute result lost under back-pressure");

    // A load request is never a result with a store on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        x_valid && x_item.kind == KIND_LOADREQ |-> !x_item.store_flag)
        else $error("load request carries store strobe");

    // Stopped and wrong-phase results carry no memory traffic.
    assert property (@(posedge clk) disable iff (!rst_n)
        x_valid && (x_item.kind == KIND_STOPPED || x_item.kind == KIND_PHASE)
        |-> x_item.byte_mask == 4'd0 && x_item.data_address == 32'd0)
        else $error("stopped result carries memory fields");
endmodule

>>> tb/tb_rv32i_execute_core.sv
// Self-checking testbench for the RV32I execute core with a built-in instruction-level predictor.
module tb_rv32i_execute_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rvx_pkg::*;

    // Configuration index that the core is expected to ignore.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    in_item_t  in_item = '0;
    logic      full;
    logic      empty;
    logic      pop = 1'b0;
    out_item_t out_item;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    rv32i_execute_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_item   (in_item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // The clock period is 2 ns.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Architectural state of the core as the predictor sees it. It is updated
    // in transfer order, so the stimulus can look at it to decide whether the
    // next item should be an instruction or the data word of a pending load.
    logic [31:0] gpr [REG_COUNT];
    logic [31:0] pc_model;
    logic        halt_model;
    logic        load_pending;
    logic [2:0]  load_f3;
    logic [4:0]  load_rd;
    logic [1:0]  load_lane;
    logic [31:0] load_instr;
    logic [31:0] load_addr;

    // Results that are predicted but not yet popped, oldest first.
    out_item_t retire_q[$];

    int  error_count = 0;
    // Idle controls: when off, the matching side adds no random pauses.
    bit  send_gaps = 1'b0;
    bit  pop_gaps = 1'b0;
    // A long receiver hold-off, picked up by the receiver process.
    int  hold_cycles = 0;

    // Prints one mismatch line and counts it.
    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
        error_count++;
    endtask

    // A stopped or wrong-phase result: only the address, word and next_fetch are set.
    function automatic out_item_t stop_result(input logic [1:0] kind, input logic [31:0] w);
        out_item_t r;
        r = '0;
        r.kind = kind;
        r.instr_address = pc_model;
        r.instr_word = w;
        r.next_fetch = pc_model;
        return r;
    endfunction

    function automatic logic signed_lt(input logic [31:0] a, input logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    // Executes one item against the model state and returns the result it causes.
    function automatic out_item_t execute_item(input in_item_t it);
        out_item_t   r;
        logic [31:0] ir, a, b, immi, npc, res, ad, bimm, jimm, v;
        logic [6:0]  op, f7;
        logic [4:0]  rd;
        logic [2:0]  f3;
        logic        wr, taken;
        logic [4:0]  sh;
        r = '0;
        ir = it.word;
        if (halt_model)
            return stop_result(KIND_STOPPED, ir);
        if (it.cmd != load_pending)
            return stop_result(KIND_PHASE, ir);

        if (it.cmd)
        begin
            // Returned data word: pick the lane and extend it.
            v = ir >> (load_lane * 8);
            case (load_f3)
                3'd0: v = {{24{v[7]}}, v[7:0]};
                3'd1: v = {{16{v[15]}}, v[15:0]};
                3'd4: v = {24'd0, v[7:0]};
                3'd5: v = {16'd0, v[15:0]};
                default: v = ir;
            endcase
            gpr[load_rd] = v;
            r.kind = KIND_RETIRED;
            r.instr_address = pc_model;
            r.instr_word = load_instr;
            r.dest_index = load_rd;
            r.write_value = v;
            r.data_address = load_addr;
            r.lane_offset = load_lane;
            gpr[0] = '0;
            pc_model = pc_model + 32'd4;
            r.next_fetch = pc_model;
            load_pending = 1'b0;
            return r;
        end

        op = ir[6:0];
        rd = ir[11:7];
        f3 = ir[14:12];
        f7 = ir[31:25];
        a = gpr[ir[19:15]];
        b = gpr[ir[24:20]];
        immi = {{20{ir[31]}}, ir[31:20]};
        npc = pc_model + 32'd4;
        wr = 1'b0;
        res = '0;
        case (op)
            OP_LUI:
            begin
                wr = 1'b1;
                res = {ir[31:12], 12'd0};
            end
            OP_AUIPC:
            begin
                wr = 1'b1;
                res = pc_model + {ir[31:12], 12'd0};
            end
            OP_JAL:
            begin
                jimm = {{11{ir[31]}}, ir[31], ir[19:12], ir[20], ir[30:21], 1'b0};
                wr = 1'b1;
                res = pc_model + 32'd4;
                npc = pc_model + jimm;
            end
            OP_JALR:
            begin
                if (f3 != 3'd0)
                    return stop_result(KIND_STOPPED, ir);
                wr = 1'b1;
                res = pc_model + 32'd4;
                // The target uses rs1 before rd is written, with bit 0 cleared.
                npc = (a + immi) & ~32'd1;
            end
            OP_BRANCH:
            begin
                bimm = {{19{ir[31]}}, ir[31], ir[7], ir[30:25], ir[11:8], 1'b0};
                case (f3)
                    3'd0: taken = (a == b);
                    3'd1: taken = (a != b);
                    3'd4: taken = signed_lt(a, b);
                    3'd5: taken = !signed_lt(a, b);
                    3'd6: taken = (a < b);
                    3'd7: taken = (a >= b);
                    default: return stop_result(KIND_STOPPED, ir);
                endcase
                if (taken)
                    npc = pc_model + bimm;
            end
            OP_LOAD:
            begin
                ad = a + immi;
                case (f3)
                    3'd0, 3'd4: load_lane = ad[1:0];
                    3'd1, 3'd5: load_lane = {ad[1], 1'b0};
                    3'd2: load_lane = 2'd0;
                    default: return stop_result(KIND_STOPPED, ir);
                endcase
                load_pending = 1'b1;
                load_f3 = f3;
                load_rd = rd;
                load_instr = ir;
                load_addr = {ad[31:2], 2'b00};
                r.kind = KIND_LOADREQ;
                r.instr_address = pc_model;
                r.instr_word = ir;
                r.dest_index = rd;
                r.data_address = load_addr;
                r.lane_offset = load_lane;
                r.next_fetch = pc_model + 32'd4;
                return r;
            end
            OP_STORE:
            begin
                ad = a + {{20{ir[31]}}, ir[31:25], ir[11:7]};
                case (f3)
                    3'd0:
                    begin
                        r.store_word = b << (ad[1:0] * 8);
                        r.byte_mask = 4'b0001 << ad[1:0];
                    end
                    3'd1:
                    begin
                        r.store_word = b << (ad[1] * 16);
                        r.byte_mask = 4'b0011 << (ad[1] * 2);
                    end
                    3'd2:
                    begin
                        r.store_word = b;
                        r.byte_mask = 4'b1111;
                    end
                    default: return stop_result(KIND_STOPPED, ir);
                endcase
                r.data_address = {ad[31:2], 2'b00};
                r.store_flag = 1'b1;
            end
            OP_IMM:
            begin
                wr = 1'b1;
                sh = ir[24:20];
                case (f3)
                    3'd0: res = a + immi;
                    3'd1:
                    begin
                        if (f7 != 7'd0)
                            return stop_result(KIND_STOPPED, ir);
                        res = a << sh;
                    end
                    3'd2: res = {31'd0, signed_lt(a, immi)};
                    3'd3: res = {31'd0, a < immi};
                    3'd4: res = a ^ immi;
                    3'd5:
                    begin
                        if (f7 == 7'd0)
                            res = a >> sh;
                        else if (f7 == 7'h20)
                            res = $signed(a) >>> sh;
                        else
                            return stop_result(KIND_STOPPED, ir);
                    end
                    3'd6: res = a | immi;
                    default: res = a & immi;
                endcase
            end
            OP_REG:
            begin
                if (f7 != 7'd0 && !(f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5)))
                    return stop_result(KIND_STOPPED, ir);
                wr = 1'b1;
                sh = b[4:0];
                case (f3)
                    3'd0: res = (f7 != 7'd0) ? a - b : a + b;
                    3'd1: res = a << sh;
                    3'd2: res = {31'd0, signed_lt(a, b)};
                    3'd3: res = {31'd0, a < b};
                    3'd4: res = a ^ b;
                    // The cast keeps the arithmetic shift signed inside the select.
                    3'd5: res = (f7 != 7'd0) ? 32'($signed(a) >>> sh) : a >> sh;
                    3'd6: res = a | b;
                    default: res = a & b;
                endcase
            end
            OP_FENCE:
            begin
                if (f3 > 3'd1)
                    return stop_result(KIND_STOPPED, ir);
            end
            OP_SYSTEM:
            begin
                if (f3 == 3'd4)
                    return stop_result(KIND_STOPPED, ir);
                if (f3 == 3'd0 && ir != SYS_ECALL && ir != SYS_EBREAK &&
                    ir != SYS_MRET && ir != SYS_WFI)
                    return stop_result(KIND_STOPPED, ir);
            end
            default: return stop_result(KIND_STOPPED, ir);
        endcase

        if (wr)
            gpr[rd] = res;
        r.kind = KIND_RETIRED;
        r.instr_address = pc_model;
        r.instr_word = ir;
        r.dest_index = rd;
        // The write value is taken before x0 is forced back to zero.
        r.write_value = gpr[rd];
        r.next_fetch = npc;
        gpr[0] = '0;
        pc_model = npc;
        return r;
    endfunction

    function automatic logic [31:0] enc_i(input logic [6:0] op, input logic [2:0] f3,
                                          input logic [4:0] rd, input logic [4:0] rs1,
                                          input logic [11:0] imm);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [2:0] f3,
                                          input logic [4:0] rd, input logic [4:0] rs1,
                                          input logic [4:0] rs2);
        return {f7, rs2, rs1, f3, rd, OP_REG};
    endfunction

    function automatic logic [31:0] enc_s(input logic [2:0] f3, input logic [4:0] rs1,
                                          input logic [4:0] rs2, input logic [11:0] imm);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    // Draws a random instruction word, mostly legal, with the fields not fixed by the opcode random.
    function automatic logic [31:0] random_instr();
        logic [31:0] w;
        logic [2:0]  f3;
        logic [6:0]  f7;
        w = $urandom();
        f3 = w[14:12];
        case ($urandom_range(0, 13))
            0: w[6:0] = OP_LUI;
            1: w[6:0] = OP_AUIPC;
            2: w[6:0] = OP_JAL;
            3: w = {w[31:15], 3'd0, w[11:7], OP_JALR};
            4:
            begin
                if (f3 == 3'd2 || f3 == 3'd3)
                    f3 = 3'd0;
                w = {w[31:15], f3, w[11:0]};
                w[6:0] = OP_BRANCH;
            end
            5, 6:
            begin
                if (f3 == 3'd3 || f3 > 3'd5)
                    f3 = 3'd2;
                w = {w[31:15], f3, w[11:7], OP_LOAD};
            end
            7:
            begin
                if (f3 > 3'd2)
                    f3 = 3'd0;
                w = {w[31:15], f3, w[11:7], OP_STORE};
            end
            8, 9:
            begin
                f7 = w[30] ? 7'h20 : 7'h00;
                if (f3 == 3'd1 || f3 == 3'd5)
                    w[31:25] = (f3 == 3'd5) ? f7 : 7'h00;
                w[6:0] = OP_IMM;
            end
            10, 11:
            begin
                f7 = (w[30] && (f3 == 3'd0 || f3 == 3'd5)) ? 7'h20 : 7'h00;
                w = {f7, w[24:0]};
                w[6:0] = OP_REG;
            end
            12:
            begin
                case ($urandom_range(0, 5))
                    0: w = SYS_ECALL;
                    1: w = SYS_EBREAK;
                    2: w = SYS_MRET;
                    3: w = SYS_WFI;
                    4: w = {w[31:15], 2'b00, w[12], w[11:7], OP_FENCE};
                    default:
                    begin
                        if (f3 == 3'd0 || f3 == 3'd4)
                            f3 = 3'd1;
                        w = {w[31:15], f3, w[11:7], OP_SYSTEM};
                    end
                endcase
            end
            default: ; // fully random word, usually an illegal instruction
        endcase
        return w;
    endfunction

    // Next item of a well-formed stream, with a little out-of-phase noise.
    function automatic in_item_t next_item();
        in_item_t it;
        it.word = $urandom();
        if ($urandom_range(0, 99) < 4)
            it.cmd = !load_pending;
        else if (load_pending)
            it.cmd = 1'b1;
        else
        begin
            it.cmd = 1'b0;
            it.word = random_instr();
        end
        return it;
    endfunction

    // Offers one item until it transfers, predicts it, then, with send_gaps set, pauses a random time.
    // Called at a rising edge; push stays high between back-to-back items.
    task automatic send_item(input in_item_t it);
        int gap;
        push <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (full);
        retire_q.push_back(execute_item(it));
        gap = send_gaps ? $urandom_range(0, 19) : 0;
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_instr(input logic [31:0] w);
        in_item_t it;
        it.cmd = 1'b0;
        it.word = w;
        send_item(it);
    endtask

    task automatic send_data(input logic [31:0] w);
        in_item_t it;
        it.cmd = 1'b1;
        it.word = w;
        send_item(it);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_item(next_item());
    endtask

    // Waits until every predicted result has been popped, then lets the
    // pipeline drain before the caller touches configuration.
    task automatic wait_idle();
        push <= 1'b0;
        while (retire_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // One configuration transfer, mirrored into the model state.
    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_INITIAL_PC: pc_model = value;
            CFG_INITIAL_SP: gpr[2] = value;
            CFG_HALT: halt_model = value[0];
            default: ;
        endcase
    endtask

    // Receiver: each result is preceded by a random wait when pop_gaps is set,
    // or by a long hold-off when a test asks for one.
    initial
    begin : receiver
        int wait_n;
        out_item_t want;
        forever
        begin
            wait_n = pop_gaps ? $urandom_range(0, 19) : 0;
            if (hold_cycles > 0)
            begin
                wait_n = hold_cycles;
                hold_cycles = 0;
            end
            if (wait_n != 0)
            begin
                pop <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty || !rst_n);
            if (retire_q.size() == 0)
                report("unexpected result", out_item.instr_word, 32'd0);
            else
            begin
                want = retire_q.pop_front();
                if (out_item.kind !== want.kind)
                    report("kind", out_item.kind, want.kind);
                if (out_item.instr_address !== want.instr_address)
                    report("instr_address", out_item.instr_address, want.instr_address);
                if (out_item.instr_word !== want.instr_word)
                    report("instr_word", out_item.instr_word, want.instr_word);
                if (out_item.dest_index !== want.dest_index)
                    report("dest_index", out_item.dest_index, want.dest_index);
                if (out_item.write_value !== want.write_value)
                    report("write_value", out_item.write_value, want.write_value);
                if (out_item.data_address !== want.data_address)
                    report("data_address", out_item.data_address, want.data_address);
                if (out_item.lane_offset !== want.lane_offset)
                    report("lane_offset", out_item.lane_offset, want.lane_offset);
                if (out_item.store_word !== want.store_word)
                    report("store_word", out_item.store_word, want.store_word);
                if (out_item.byte_mask !== want.byte_mask)
                    report("byte_mask", out_item.byte_mask, want.byte_mask);
                if (out_item.store_flag !== want.store_flag)
                    report("store_flag", out_item.store_flag, want.store_flag);
                if (out_item.next_fetch !== want.next_fetch)
                    report("next_fetch", out_item.next_fetch, want.next_fetch);
            end
        end
    end

    // Directed instructions: extreme immediates, every load and store width, mostly at
    // odd offsets, shifts, JALR with an odd target, the no-op system group,
    // illegal encodings and both kinds of out-of-phase item.
    task automatic test_directed();
        send_instr({20'hfffff, 5'd1, OP_LUI});
        send_instr(enc_i(OP_IMM, 3'd0, 5'd3, 5'd0, 12'hfff));
        send_instr(enc_i(OP_IMM, 3'd0, 5'd4, 5'd0, 12'h7ff));
        send_instr(enc_i(OP_IMM, 3'd5, 5'd5, 5'd1, {7'h20, 5'd31}));
        send_instr(enc_r(7'h20, 3'd0, 5'd6, 5'd4, 5'd3));
        send_instr(enc_i(OP_IMM, 3'd0, 5'd0, 5'd4, 12'h001));
        send_instr({20'h80000, 5'd7, OP_AUIPC});
        send_instr(enc_i(OP_LOAD, 3'd0, 5'd8, 5'd4, 12'h004));
        send_data(32'h80ff_7f01);
        send_instr(enc_i(OP_LOAD, 3'd1, 5'd9, 5'd3, 12'h004));
        send_data(32'h8001_7fff);
        send_instr(enc_i(OP_LOAD, 3'd2, 5'd10, 5'd4, 12'h002));
        send_data(32'hdead_beef);
        send_instr(enc_i(OP_LOAD, 3'd4, 5'd0, 5'd0, 12'h003));
        send_instr(32'h0000_0013);
        send_data(32'hff00_0000);
        send_instr(enc_i(OP_LOAD, 3'd5, 5'd11, 5'd0, 12'h002));
        send_data(32'hffff_0000);
        send_data(32'h1234_5678);
        send_instr(enc_s(3'd0, 5'd4, 5'd3, 12'h004));
        send_instr(enc_s(3'd1, 5'd4, 5'd3, 12'h003));
        send_instr(enc_s(3'd2, 5'd0, 5'd1, 12'h801));
        send_instr(enc_i(OP_JALR, 3'd0, 5'd12, 5'd4, 12'h002));
        send_instr(SYS_ECALL);
        send_instr(SYS_EBREAK);
        send_instr(SYS_MRET);
        send_instr(SYS_WFI);
        send_instr({12'h300, 5'd1, 3'd1, 5'd13, OP_SYSTEM});
        send_instr(enc_i(OP_FENCE, 3'd1, 5'd0, 5'd0, 12'h0ff));
        send_instr(32'h0000_0000);
        send_instr(32'hffff_ffff);
    endtask

    // With the halt request set, every item is stopped and nothing changes.
    task automatic test_halt();
        write_cfg(CFG_HALT, 32'd1);
        send_random(6);
        send_data($urandom());
        write_cfg(CFG_HALT, 32'd0);
    endtask

    // Long receiver stall while the sender keeps offering: the core fills up
    // and must hold off the input without losing or reordering anything.
    task automatic test_backpressure();
        send_gaps = 1'b0;
        hold_cycles = 300;
        send_random(80);
        pop_gaps = 1'b1;
        send_gaps = 1'b1;
        send_random(20);
    endtask

    // Random streams under several reset values, including the extremes.
    task automatic test_random();
        write_cfg(CFG_INITIAL_PC, 32'hffff_fffc);
        write_cfg(CFG_INITIAL_SP, 32'hffff_ffff);
        send_random(150);
        write_cfg(CFG_UNUSED, $urandom());
        write_cfg(CFG_INITIAL_PC, 32'h0000_0000);
        write_cfg(CFG_INITIAL_SP, 32'h0000_0000);
        send_random(150);
        for (int phase = 0; phase < 8; phase++)
        begin
            send_gaps = phase[0];
            pop_gaps = phase[1] | phase[2];
            write_cfg(CFG_INITIAL_PC, $urandom());
            write_cfg(CFG_INITIAL_SP, $urandom());
            send_random(110);
        end
    endtask

    initial
    begin : stimulus
        for (int i = 0; i < REG_COUNT; i++)
            gpr[i] = '0;
        pc_model = '0;
        halt_model = 1'b0;
        load_pending = 1'b0;
        load_f3 = '0;
        load_rd = '0;
        load_lane = '0;
        load_instr = '0;
        load_addr = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        pop_gaps = 1'b1;
        send_gaps = 1'b1;
        test_halt();
        test_backpressure();
        test_random();

        wait_idle();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin : watchdog
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> rv32i_execute_core.f
hw/rtl/rvx_pkg.sv
hw/rtl/rvx_queue.sv
hw/rtl/rvx_exec.sv
hw/rtl/rv32i_execute_core.sv
tb/tb_rv32i_execute_core.sv
